@@ rtl/pcc_pkg.sv @@
// ============================================================================
// pcc_pkg
// Shared types, constants and helper functions for the paced calendar clock.
// ============================================================================
package pcc_pkg;

    // Default catch-up budget, in whole days.
    localparam int MAX_CATCH_UP_DEF = 8;

    // Longest day period in ms (speed 1).
    localparam int PERIOD_MAX = 2000;
    localparam int PER_W      = 11;

    // Field widths
    localparam int YEAR_W  = 16;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int SPEED_W = 3;
    localparam int ELAP_W  = 16;

    // Reset values and limits
    localparam logic [YEAR_W-1:0]  YEAR_RESET = 16'd1910;
    localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST  = 5'd1;
    localparam logic [SPEED_W-1:0] SPEED_MIN  = 3'd1;
    localparam logic [SPEED_W-1:0] SPEED_MAX  = 3'd4;

    // Command codes
    localparam logic [1:0] CMD_ELAPSED = 2'd0;
    localparam logic [1:0] CMD_PAUSE   = 2'd1;
    localparam logic [1:0] CMD_FASTER  = 2'd2;
    localparam logic [1:0] CMD_SLOWER  = 2'd3;

    // Input word
    typedef struct packed {
        logic [1:0]        cmd;
        logic [ELAP_W-1:0] elapsed_ms;
    } t_in_word;

    // Output word
    typedef struct packed {
        logic               day_advanced;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day_of_month;
        logic [SPEED_W-1:0] speed;
        logic               paused;
        logic               last;
    } t_out_word;

    // Controller to datapath
    typedef struct packed {
        logic load;      // latch accepted input word
        logic apply;     // execute the command
        logic step_day;  // advance one day, spend one period
        logic emit;      // load the output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic pending;   // a whole period is waiting in day mode
        logic last_day;  // the pending day is the final one
    } t_dp_status;

    // Day length in ms: 10 * (260 - 60 * speed)
    function automatic logic [PER_W-1:0] period_ms(input logic [SPEED_W-1:0] speed);
        logic [PER_W-1:0] p;
        case (speed)
            3'd1:    p = 11'd2000;
            3'd2:    p = 11'd1400;
            3'd3:    p = 11'd800;
            3'd4:    p = 11'd200;
            default: p = 11'd2000;
        endcase
        return p;
    endfunction

    // Month length; February follows the year-divisible-by-four rule
    function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] month,
                                                       input logic [YEAR_W-1:0]  year);
        logic [DAY_W-1:0] d;
        case (month)
            4'd2:    d = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:
                     d = 5'd30;
            default: d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

@@ rtl/paced_calendar_clock.sv @@
// ============================================================================
// paced_calendar_clock
// Day/month/year calendar clock paced by elapsed-time, pause and speed words.
// ============================================================================
// One input word is handled at a time. A pause or speed word, or an elapsed
// word that completes no day, passes through the accept, apply and emit
// states, and the emit state loads its single result word into the output
// register. An elapsed word that completes N days (N up to MAX_CATCH_UP)
// passes through accept and apply and then stays in emit: the day-step unit
// in the datapath advances one day and loads one result word per cycle, and
// it waits whenever the output register is still held by a stalled receiver.
// The input is stalled from accept until the last result word of that item
// is in the output register.
module paced_calendar_clock #(
    parameter int MAX_CATCH_UP = pcc_pkg::MAX_CATCH_UP_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  pcc_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output pcc_pkg::t_out_word o_out_word
);
    import pcc_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Sequencer
    pcc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Calendar datapath
    pcc_dp #(
        .MAX_CATCH_UP (MAX_CATCH_UP)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_word  (i_in_word),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_out_word (o_out_word)
    );

endmodule

@@ rtl/pcc_ctrl.sv @@
// ============================================================================
// pcc_ctrl
// Sequencer for the paced calendar clock: accepts a word, applies it, then
// emits one result per advanced day (or one status result) into the output
// register.
// ============================================================================
module pcc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  pcc_pkg::t_dp_status i_status,
    output pcc_pkg::t_dp_cmd    o_cmd
);
    import pcc_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_APPLY = 2'd1;
    localparam logic [1:0] S_EMIT  = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_out_free;
    t_dp_cmd    w_cmd;

    assign w_out_free = !r_out_valid || !i_out_stall;

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_APPLY;
                end
            end
            S_APPLY: begin
                w_cmd.apply = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    w_cmd.emit     = 1'b1;
                    w_cmd.step_day = i_status.pending;
                    if (!i_status.pending || i_status.last_day) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output valid: set on load, cleared once taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

`ifndef SYNTHESIS
    // never overwrite a word that is still held by a stalled receiver
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.emit && r_out_valid && i_out_stall))
        else $error("output word overwritten while stalled");

    // one item at a time: an accepted word closes the input
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input open right after accept");

    // a day step only comes with an output load
    a_step_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.step_day |-> (w_cmd.emit && r_state == S_EMIT))
        else $error("day step without emit");
`endif

endmodule

@@ rtl/pcc_dp.sv @@
// ============================================================================
// pcc_dp
// Datapath for the paced calendar clock: calendar, speed, pause flag, ms
// accumulator with catch-up clamp, and the output word register.
// ============================================================================
module pcc_dp #(
    parameter int MAX_CATCH_UP = pcc_pkg::MAX_CATCH_UP_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pcc_pkg::t_in_word   i_in_word,
    input  pcc_pkg::t_dp_cmd    i_cmd,
    output pcc_pkg::t_dp_status o_status,
    output pcc_pkg::t_out_word  o_out_word
);
    import pcc_pkg::*;

    localparam int ACC_W = $clog2(PERIOD_MAX * MAX_CATCH_UP + 1);
    localparam int SUM_W = ((ACC_W > ELAP_W) ? ACC_W : ELAP_W) + 1;

    // Architectural state
    logic [YEAR_W-1:0]  r_year,  n_year;
    logic [MONTH_W-1:0] r_month, n_month;
    logic [DAY_W-1:0]   r_day,   n_day;
    logic [SPEED_W-1:0] r_speed, n_speed;
    logic               r_paused, n_paused;
    logic [ACC_W-1:0]   r_acc,   n_acc;

    // Latched item and mode
    t_in_word           r_item;
    logic               r_days_mode;
    t_out_word          r_out_word;

    logic [PER_W-1:0]   w_period;
    logic [ACC_W-1:0]   w_period_ext;
    logic [ACC_W-1:0]   w_budget;
    logic [SUM_W-1:0]   w_sum;
    logic [ACC_W-1:0]   w_rem;
    logic               w_pending;
    logic [YEAR_W-1:0]  w_nd_year;
    logic [MONTH_W-1:0] w_nd_month;
    logic [DAY_W-1:0]   w_nd_day;

    // Period and catch-up budget for the current speed
    assign w_period     = period_ms(r_speed);
    assign w_period_ext = ACC_W'(w_period);
    assign w_budget     = w_period_ext * ACC_W'(MAX_CATCH_UP);
    assign w_sum        = SUM_W'(r_acc) + SUM_W'(r_item.elapsed_ms);

    // Pending day check and remainder after one period
    assign w_pending = r_days_mode && (r_acc >= w_period_ext);
    assign w_rem     = r_acc - w_period_ext;

    assign o_status.pending  = w_pending;
    assign o_status.last_day = (w_rem < w_period_ext);

    // Calendar after one more day
    always_comb begin
        w_nd_year  = r_year;
        w_nd_month = r_month;
        w_nd_day   = r_day + DAY_FIRST;
        if (r_day >= days_in_month(r_month, r_year)) begin
            w_nd_day = DAY_FIRST;
            if (r_month >= MONTH_DEC) begin
                w_nd_month = MONTH_JAN;
                w_nd_year  = r_year + YEAR_W'(1);
            end else begin
                w_nd_month = r_month + MONTH_W'(1);
            end
        end
    end

    // State update
    always_comb begin
        n_year   = r_year;
        n_month  = r_month;
        n_day    = r_day;
        n_speed  = r_speed;
        n_paused = r_paused;
        n_acc    = r_acc;
        if (i_cmd.apply) begin
            unique case (r_item.cmd)
                CMD_ELAPSED: begin
                    if (!r_paused) begin
                        n_acc = (w_sum > SUM_W'(w_budget)) ? w_budget : ACC_W'(w_sum);
                    end
                end
                CMD_PAUSE: begin
                    n_paused = !r_paused;
                    n_acc    = '0;
                end
                CMD_FASTER: begin
                    if (r_speed < SPEED_MAX) n_speed = r_speed + SPEED_W'(1);
                end
                CMD_SLOWER: begin
                    if (r_speed > SPEED_MIN) n_speed = r_speed - SPEED_W'(1);
                end
                default: ;
            endcase
        end else if (i_cmd.step_day) begin
            n_year  = w_nd_year;
            n_month = w_nd_month;
            n_day   = w_nd_day;
            n_acc   = w_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year      <= YEAR_RESET;
            r_month     <= MONTH_JAN;
            r_day       <= DAY_FIRST;
            r_speed     <= SPEED_MIN;
            r_paused    <= 1'b0;
            r_acc       <= '0;
            r_days_mode <= 1'b0;
        end else begin
            r_year   <= n_year;
            r_month  <= n_month;
            r_day    <= n_day;
            r_speed  <= n_speed;
            r_paused <= n_paused;
            r_acc    <= n_acc;
            if (i_cmd.apply) begin
                r_days_mode <= (r_item.cmd == CMD_ELAPSED) && !r_paused;
            end
        end
    end

    // Item latch and output word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_word;
        end
        if (i_cmd.emit) begin
            r_out_word.day_advanced <= i_cmd.step_day;
            r_out_word.year         <= i_cmd.step_day ? w_nd_year  : r_year;
            r_out_word.month        <= i_cmd.step_day ? w_nd_month : r_month;
            r_out_word.day_of_month <= i_cmd.step_day ? w_nd_day   : r_day;
            r_out_word.speed        <= r_speed;
            r_out_word.paused       <= r_paused;
            r_out_word.last         <= !i_cmd.step_day || o_status.last_day;
        end
    end

    assign o_out_word = r_out_word;

`ifndef SYNTHESIS
    // month stays a real month
    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_month >= MONTH_JAN) && (r_month <= MONTH_DEC))
        else $error("month out of range");

    // day stays within the month
    a_day_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_day >= DAY_FIRST) && (r_day <= days_in_month(r_month, r_year)))
        else $error("day out of range");

    // a day step spends exactly one period
    a_spend_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step_day |=> (r_acc == $past(w_rem)))
        else $error("accumulator not reduced by one period");
`endif

endmodule
